FILE: rtl/gad_pkg.sv
// Package for the growable array block: payload structs, codes and defaults.
// Used by gad_ctrl and growable_array_with_delete; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gad_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int CAP_RESET       = 10;

    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 7;
    localparam int CAP_W   = 7;

    localparam logic [FUNC_W-1:0] FUNC_APPEND    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE_LAST = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE_AT = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NONE     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] removed_value;
        logic [STAT_W-1:0]         status;
        logic [CNT_W-1:0]          count;
        logic [CAP_W-1:0]          current_capacity;
        logic                      empty_res;
    } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/gad_mem.sv
// Word store of the growable array: one write port, one read port, registered read.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module gad_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/gad_ctrl.sv
// Request sequencer: count/capacity bookkeeping, memory reads, shift-down pass.
// Depends on gad_pkg; drives the port of gad_mem.
`timescale 1ns / 1ps
`default_nettype none

module gad_ctrl #(
    parameter int MAX_ENTRIES = gad_pkg::MAX_ENTRIES_DEF,
    parameter int DATA_WIDTH  = gad_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire gad_pkg::req_t                  req,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [gad_pkg::CAP_W-1:0]      cfg_data,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output gad_pkg::rsp_t                       res,
    output logic                                mem_we,
    output logic [$clog2(MAX_ENTRIES)-1:0]      mem_waddr,
    output logic [DATA_WIDTH-1:0]               mem_wdata,
    output logic                                mem_re,
    output logic [$clog2(MAX_ENTRIES)-1:0]      mem_raddr,
    input  wire logic [DATA_WIDTH-1:0]          mem_rdata
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (CW > gad_pkg::CNT_W) ? CW : gad_pkg::CNT_W;
    localparam int VW = gad_pkg::VALUE_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);
    localparam logic [XW-1:0] MAX_X = XW'(MAX_ENTRIES);
    localparam logic [CW-1:0] CAP_INIT =
        (gad_pkg::CAP_RESET > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(gad_pkg::CAP_RESET);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          cap_reg, cap_next;
    logic                   wr_pend_reg, wr_pend_next;
    logic [gad_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [gad_pkg::STAT_W-1:0] status_reg, status_next;
    logic [VW-1:0]          removed_reg, removed_next;
    logic [CW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]          last_reg, last_next;
    logic [AW-1:0]          wr_addr_reg, wr_addr_next;

    logic                   accept;
    logic [DATA_WIDTH-1:0]  wr_word;
    logic [VW-1:0]          rd_word;
    logic [XW-1:0]          pos_x, pos_m1, cnt_x, cap_x, cfg_x;
    logic [CW-1:0]          cnt_m1, cap_shr, cfg_cap;
    logic [CW:0]            grown;
    logic [CW-1:0]          rd_ptr_m1;

    generate
        if (DATA_WIDTH < VW)
        begin : g_narrow
            assign wr_word = req.value[DATA_WIDTH-1:0];
            assign rd_word = {{(VW - DATA_WIDTH){mem_rdata[DATA_WIDTH-1]}}, mem_rdata};
        end
        else if (DATA_WIDTH == VW)
        begin : g_equal
            assign wr_word = req.value;
            assign rd_word = mem_rdata;
        end
        else
        begin : g_wide
            assign wr_word = {{(DATA_WIDTH - VW){req.value[VW-1]}}, req.value};
            assign rd_word = mem_rdata[VW-1:0];
        end
    endgenerate

    assign accept    = req_valid && (state_reg == S_IDLE);
    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    assign pos_x     = XW'(req.position);
    assign pos_m1    = pos_x - XW'(1);
    assign cnt_x     = XW'(count_reg);
    assign cap_x     = XW'(cap_reg);
    assign cfg_x     = XW'(cfg_data);
    assign cnt_m1    = count_reg - CW'(1);
    assign grown     = {cap_reg, 1'b0};
    assign rd_ptr_m1 = rd_ptr_reg - CW'(1);

    // capacity after a removal that leaves cnt_m1 words
    assign cap_shr = (cnt_m1 < (cap_reg >> 2)) ? (cap_reg >> 1) : cap_reg;

    always_comb
    begin
        if (cfg_x == '0)
        begin
            cfg_cap = CW'(1);
        end
        else if (cfg_x > MAX_X)
        begin
            cfg_cap = MAX_C;
        end
        else
        begin
            cfg_cap = CW'(cfg_data);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        cap_next     = cap_reg;
        wr_pend_next = wr_pend_reg;
        func_next    = func_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        rd_ptr_next  = rd_ptr_reg;
        last_next    = last_reg;
        wr_addr_next = wr_addr_reg;
        mem_we       = 1'b0;
        mem_waddr    = count_reg[AW-1:0];
        mem_wdata    = wr_word;
        mem_re       = 1'b0;
        mem_raddr    = cnt_m1[AW-1:0];
        res_valid    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid && (count_reg == '0))
                begin
                    cap_next = cfg_cap;
                end
                if (accept)
                begin
                    func_next    = req.func;
                    status_next  = gad_pkg::STAT_DONE;
                    removed_next = '0;
                    wr_pend_next = 1'b0;
                    state_next   = S_DONE;
                    case (req.func)
                        gad_pkg::FUNC_APPEND:
                        begin
                            if (count_reg == MAX_C)
                            begin
                                status_next = gad_pkg::STAT_FULL;
                            end
                            else
                            begin
                                if (count_reg >= cap_reg)
                                begin
                                    cap_next = (grown > {1'b0, MAX_C}) ? MAX_C : grown[CW-1:0];
                                end
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        gad_pkg::FUNC_REMOVE_LAST:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = gad_pkg::STAT_NONE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                count_next = cnt_m1;
                                cap_next   = cap_shr;
                                state_next = S_READ;
                            end
                        end
                        gad_pkg::FUNC_REMOVE_AT:
                        begin
                            if ((pos_x == '0) || (pos_x > cnt_x))
                            begin
                                status_next = gad_pkg::STAT_NONE;
                            end
                            else
                            begin
                                mem_re      = 1'b1;
                                mem_raddr   = pos_m1[AW-1:0];
                                rd_ptr_next = CW'(req.position);
                                last_next   = count_reg;
                                count_next  = cnt_m1;
                                cap_next    = cap_shr;
                                state_next  = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                removed_next = rd_word;
                state_next   = (func_reg == gad_pkg::FUNC_REMOVE_AT) ? S_SHIFT : S_DONE;
            end
            S_SHIFT:
            begin
                // read word k while writing word k-1 read the cycle before
                mem_we    = wr_pend_reg;
                mem_waddr = wr_addr_reg;
                mem_wdata = mem_rdata;
                mem_raddr = rd_ptr_reg[AW-1:0];
                if (rd_ptr_reg < last_reg)
                begin
                    mem_re       = 1'b1;
                    wr_addr_next = rd_ptr_m1[AW-1:0];
                    rd_ptr_next  = rd_ptr_reg + CW'(1);
                    wr_pend_next = 1'b1;
                end
                else
                begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.removed_value    = removed_reg;
        res.status           = status_reg;
        res.count            = cnt_x[gad_pkg::CNT_W-1:0];
        res.current_capacity = cap_x[gad_pkg::CAP_W-1:0];
        res.empty_res        = (count_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cap_reg     <= CAP_INIT;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cap_reg     <= cap_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        rd_ptr_reg  <= rd_ptr_next;
        last_reg    <= last_next;
        wr_addr_reg <= wr_addr_next;
    end

endmodule

`default_nettype wire

FILE: rtl/growable_array_with_delete.sv
// Top level of the growable array: sequencer, word store and result register.
// Depends on gad_pkg, gad_mem and gad_ctrl.
//
//   channel   dir   handshake            word
//   req       in    req_valid/req_stall  gad_pkg::req_t (func, value, position)
//   rsp       out   rsp_valid/rsp_stall  gad_pkg::rsp_t (removed_value .. empty_res)
//   cfg       in    cfg_valid/cfg_ready  initial capacity, 7 bits
//
// Append, unused-selector and rejected requests go from idle straight to the result;
// remove-last passes through a read state, and remove-at through a read state and
// the shift pass that reads one word and writes the one below it each cycle.
// A result reaches rsp in the cycle after the sequencer ends; while rsp stalls one
// more request is let in and its result waits in the sequencer with req stalled.
// Reset clears count and loads the reset capacity; stored words are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module growable_array_with_delete #(
    parameter int MAX_ENTRIES = gad_pkg::MAX_ENTRIES_DEF,
    parameter int DATA_WIDTH  = gad_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire gad_pkg::req_t             req,
    output logic                           rsp_valid,
    input  wire logic                      rsp_stall,
    output gad_pkg::rsp_t                  rsp,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [gad_pkg::CAP_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_ENTRIES);

    logic                  res_valid;
    logic                  res_ready;
    gad_pkg::rsp_t         res;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic                  rsp_valid_reg, rsp_valid_next;
    gad_pkg::rsp_t         rsp_reg, rsp_next;
    logic                  load;

    gad_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    gad_mem #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !rsp_valid_reg || !rsp_stall;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_next       = res;
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for growable_array_with_delete: append, remove-last,
// remove-at, capacity growth and halving, register loads, flow control.
// Depends on gad_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_ENTRIES = gad_pkg::MAX_ENTRIES_DEF;
    localparam int AW          = $clog2(MAX_ENTRIES);
    localparam int FUNC_W      = gad_pkg::FUNC_W;
    localparam int VALUE_W     = gad_pkg::VALUE_W;
    localparam int POS_W       = gad_pkg::POS_W;
    localparam int CNT_W       = gad_pkg::CNT_W;
    localparam int CAP_W       = gad_pkg::CAP_W;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int END_WAIT    = 80;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    gad_pkg::req_t req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    gad_pkg::rsp_t rsp;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CAP_W-1:0] cfg_data = '0;

    // list model
    logic signed [VALUE_W-1:0] list_words [MAX_ENTRIES];
    logic [CNT_W-1:0] word_count;
    logic [CAP_W-1:0] cap_now;
    gad_pkg::rsp_t expected_rsp [$];
    gad_pkg::rsp_t exp_word;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int error_count = 0;
    int unsigned cycle_count = 0;

    growable_array_with_delete uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d words still expected", $time, expected_rsp.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic gad_pkg::req_t mk_req(input logic [FUNC_W-1:0] f,
                                             input logic [VALUE_W-1:0] v,
                                             input logic [POS_W-1:0] p);
        gad_pkg::req_t r;
        r.func = f;
        r.value = v;
        r.position = p;
        return r;
    endfunction

    function automatic gad_pkg::rsp_t predict_list_op(input gad_pkg::req_t r);
        gad_pkg::rsp_t o;
        int grown;
        int pos;
        o = '0;
        o.status = gad_pkg::STAT_DONE;
        pos = int'(r.position);
        case (r.func)
            gad_pkg::FUNC_APPEND:
                if (word_count >= MAX_ENTRIES)
                    o.status = gad_pkg::STAT_FULL;
                else
                begin
                    if (word_count >= cap_now)
                    begin
                        grown = int'(cap_now) * 2;
                        cap_now = (grown > MAX_ENTRIES) ? CAP_W'(MAX_ENTRIES) : CAP_W'(grown);
                    end
                    list_words[word_count[AW-1:0]] = r.value;
                    word_count = word_count + CNT_W'(1);
                end
            gad_pkg::FUNC_REMOVE_LAST:
                if (word_count == 0)
                    o.status = gad_pkg::STAT_NONE;
                else
                begin
                    word_count = word_count - CNT_W'(1);
                    o.removed_value = list_words[word_count[AW-1:0]];
                    if (word_count < cap_now / CAP_W'(4))
                        cap_now = cap_now / CAP_W'(2);
                end
            gad_pkg::FUNC_REMOVE_AT:
                if (pos == 0 || pos > int'(word_count))
                    o.status = gad_pkg::STAT_NONE;
                else
                begin
                    o.removed_value = list_words[pos - 1];
                    for (int i = pos - 1; i + 1 < int'(word_count); i++)
                        list_words[i] = list_words[i + 1];
                    word_count = word_count - CNT_W'(1);
                    if (word_count < cap_now / CAP_W'(4))
                        cap_now = cap_now / CAP_W'(2);
                end
            default: ;
        endcase
        o.count = word_count;
        o.current_capacity = cap_now;
        o.empty_res = (word_count == 0);
        return o;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h", $time, rsp);
                error_count++;
            end
            else
            begin
                exp_word = expected_rsp.pop_front();
                check_field("removed_value", exp_word.removed_value, rsp.removed_value);
                check_field("status", 32'(exp_word.status), 32'(rsp.status));
                check_field("count", 32'(exp_word.count), 32'(rsp.count));
                check_field("current_capacity", 32'(exp_word.current_capacity),
                            32'(rsp.current_capacity));
                check_field("empty_res", 32'(exp_word.empty_res), 32'(rsp.empty_res));
            end
        end
    end

    task automatic send_req(input gad_pkg::req_t r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_rsp.push_back(predict_list_op(r));
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        wait_drained();
        repeat (2) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (word_count == 0)
            cap_now = (v == '0) ? CAP_W'(1) :
                      ((int'(v) > MAX_ENTRIES) ? CAP_W'(MAX_ENTRIES) : v);
    endtask

    task automatic empty_list();
        while (word_count != 0)
            send_req(mk_req(gad_pkg::FUNC_REMOVE_LAST, $urandom,
                            POS_W'($urandom_range(127))));
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        send_req(mk_req(gad_pkg::FUNC_REMOVE_LAST, 32'h0, 7'd0));
        send_req(mk_req(gad_pkg::FUNC_REMOVE_AT, 32'h0, 7'd1));
        send_req(mk_req(FUNC_UNUSED, 32'hFFFF_FFFF, 7'd127));
        send_req(mk_req(gad_pkg::FUNC_APPEND, 32'h7FFF_FFFF, 7'd0));
        send_req(mk_req(gad_pkg::FUNC_APPEND, 32'h8000_0000, 7'd127));
        send_req(mk_req(gad_pkg::FUNC_APPEND, 32'h0000_0000, 7'd0));
        send_req(mk_req(gad_pkg::FUNC_APPEND, 32'hFFFF_FFFF, 7'd0));
        send_req(mk_req(gad_pkg::FUNC_REMOVE_AT, 32'h0, 7'd0));
        send_req(mk_req(gad_pkg::FUNC_REMOVE_AT, 32'h0, 7'd5));
        send_req(mk_req(gad_pkg::FUNC_REMOVE_AT, 32'h0, 7'd127));
        send_req(mk_req(gad_pkg::FUNC_REMOVE_AT, 32'h0, 7'd2));
        send_req(mk_req(gad_pkg::FUNC_REMOVE_AT, 32'h0, 7'd3));
        send_req(mk_req(gad_pkg::FUNC_REMOVE_LAST, 32'h0, 7'd0));
        send_req(mk_req(gad_pkg::FUNC_REMOVE_LAST, 32'h0, 7'd0));
        write_capacity(7'd1);
        send_req(mk_req(gad_pkg::FUNC_APPEND, 32'h1234_5678, 7'd0));
        send_req(mk_req(gad_pkg::FUNC_APPEND, 32'hDEAD_BEEF, 7'd0));
        send_req(mk_req(gad_pkg::FUNC_APPEND, 32'h0BAD_F00D, 7'd0));
        // not empty: the write is ignored, capacity stays
        write_capacity(7'd127);
        empty_list();
        write_capacity(7'd0);
        send_req(mk_req(gad_pkg::FUNC_APPEND, 32'h5555_AAAA, 7'd0));
        send_req(mk_req(gad_pkg::FUNC_REMOVE_AT, 32'h0, 7'd1));
        wait_drained();
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_token++;
        for (int i = 0; i < 40; i++)
            send_req(mk_req(gad_pkg::FUNC_APPEND, $urandom, POS_W'($urandom_range(127))));
        // sender pauses until every word is back
        wait_drained();
    endtask

    task automatic test_fill_drain();
        idle_pct = 15;
        stall_pct = 15;
        empty_list();
        write_capacity(7'd0);
        for (int i = 0; i < MAX_ENTRIES + 2; i++)
            send_req(mk_req(gad_pkg::FUNC_APPEND, $urandom, POS_W'($urandom_range(127))));
        while (word_count != 0)
            send_req(mk_req(gad_pkg::FUNC_REMOVE_AT, $urandom,
                            POS_W'($urandom_range(int'(word_count), 1))));
        wait_drained();
    endtask

    task automatic test_random_mix(input int idle, input int stall,
                                   input logic [CAP_W-1:0] cap_cfg, input int n);
        gad_pkg::req_t r;
        bit grow;
        int roll;
        idle_pct = idle;
        stall_pct = stall;
        empty_list();
        write_capacity(cap_cfg);
        grow = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (word_count == MAX_ENTRIES)
                grow = 1'b0;
            else if (word_count == 0)
                grow = 1'b1;
            roll = $urandom_range(99);
            r = mk_req(gad_pkg::FUNC_APPEND, $urandom, POS_W'($urandom_range(127)));
            if (roll < 2)
                r.func = FUNC_UNUSED;
            else if (roll < 5)
                r.func = gad_pkg::FUNC_REMOVE_AT;
            else if (grow ? (roll < 85) : (roll >= 90))
                r.func = gad_pkg::FUNC_APPEND;
            else if (roll % 2 == 0)
                r.func = gad_pkg::FUNC_REMOVE_LAST;
            else
            begin
                r.func = gad_pkg::FUNC_REMOVE_AT;
                if (word_count != 0)
                    r.position = POS_W'($urandom_range(int'(word_count), 1));
            end
            send_req(r);
        end
        wait_drained();
    endtask

    initial
    begin
        word_count = '0;
        cap_now = CAP_W'(gad_pkg::CAP_RESET);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_fill_drain();
        test_random_mix(0, 0, 7'd64, 100);
        test_random_mix(52, 0, 7'd3, 100);
        test_random_mix(0, 52, 7'd127, 100);
        test_random_mix(15, 15, CAP_W'($urandom_range(127)), 100);

        wait_drained();
        repeat (END_WAIT) @(posedge clk);
        if (error_count == 0 && expected_rsp.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/gad_pkg.sv
rtl/gad_mem.sv
rtl/gad_ctrl.sv
rtl/growable_array_with_delete.sv
sim/tb_top.sv
